// ===== rtl/irp_pkg.sv =====
package irp_pkg;

    typedef enum logic [1:0] {
        KIND_INTERSPACE = 2'd0,
        KIND_PULSE      = 2'd1,
        KIND_SPACE      = 2'd2,
        KIND_SUMMARY    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_PARTIAL  = 2'd1,
        ST_EARLY    = 2'd2,
        ST_NOFREQ   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PH_INTERSPACE = 2'd0,
        PH_PULSE      = 2'd1,
        PH_SPACE      = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        DONE_OPEN     = 2'd0,
        DONE_PARTIAL  = 2'd1,
        DONE_COMPLETE = 2'd2,
        DONE_EARLY    = 2'd3
    } t_done;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DIV    = 3'd1,
        S_MUL    = 3'd2,
        S_ACC    = 3'd3,
        S_EMIT   = 3'd4,
        S_SUMDIV = 3'd5,
        S_SUM    = 3'd6
    } t_state;

    typedef struct packed {
        logic     take;       // latch input byte, parse it
        logic     div_start;  // start 250000/duration
        logic     div_step;
        logic     mul;        // form frequency term
        logic     acc;        // add term to total
        logic     sdiv_start; // start total/sample_count
        logic     sdiv_step;
        logic     load_item;  // load pending parse item to output
        logic     load_sum;   // load summary to output
    } t_cmd;

    typedef struct packed {
        logic     has_item;   // parsed byte produced a pulse/space/interspace
        logic     has_sample; // pulse produced frequency sample
        logic     has_sum;    // frame or buffer ended on this byte
        logic     skip;       // byte ignored
        logic     div_done;
        logic     out_busy;   // output register full and not being taken
    } t_stat;

    localparam logic [17:0] FREQ_NUM = 18'd250000;
    localparam logic [7:0]  END_BYTE = 8'hFF;
    localparam logic [15:0] LIMIT_RESET = 16'h3E80;

endpackage

// ===== rtl/irp_ctrl.sv =====
module irp_ctrl
    import irp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                // parse result known now
                if (i_stat.skip) begin
                    n_state = S_IDLE;
                end else if (i_stat.has_sample) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_stat.has_item) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.load_item = 1'b1;
                        if (i_stat.has_sum) begin
                            o_cmd.sdiv_start = 1'b1;
                            n_state = S_SUMDIV;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_stat.has_sum) begin
                    o_cmd.sdiv_start = 1'b1;
                    n_state = S_SUMDIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_EMIT;
            end
            S_SUMDIV: begin
                o_cmd.sdiv_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_sum = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> r_state == S_EMIT)
        else $error("take not followed by emit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_item && o_cmd.load_sum))
        else $error("double load");
endmodule

// ===== rtl/irp_datapath.sv =====
module irp_datapath
    import irp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_duration,
    output logic [14:0] o_carrier_cycles,
    output logic [31:0] o_carrier_freq,
    output logic [15:0] o_pulse_count,
    output logic [15:0] o_space_count,
    output logic [15:0] o_bytes_consumed,
    output logic [15:0] o_bytes_used,
    output logic [1:0]  o_status
);
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [15:0] r_limit;
    t_phase      r_phase;
    logic [1:0]  r_fidx;
    logic [15:0] r_partial, r_pdur;
    logic [31:0] r_total;
    logic [COUNT_WIDTH-1:0] r_samples, r_pulses, r_spaces, r_bytes;
    t_done       r_done;

    // pending item of current byte
    logic        r_has_item, r_has_sample, r_has_sum, r_skip;
    logic [1:0]  r_ikind;
    logic [15:0] r_idur;
    logic [14:0] r_icyc;

    // shared restoring divider, 32-bit dividend over 16-bit duration or COUNT_WIDTH-bit count
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic [31:0] r_term;
    logic [31:0] r_avg;

    logic        r_ovalid;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (v == CMAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [15:0] cap16(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // parse one byte
    always_ff @(posedge i_clk) begin
        logic [15:0] v;
        logic [31:0] s;
        t_phase      ph;
        logic [1:0]  fi;
        t_done       dn;
        logic [COUNT_WIDTH-1:0] pc, sc, bc;
        logic [14:0] c;
        logic        have;
        logic [15:0] pt, pd;
        logic        hi, hsa, hsu;
        if (!i_rst_n) begin
            r_phase <= PH_INTERSPACE;
            r_fidx <= '0; r_partial <= '0; r_pdur <= '0; r_total <= '0;
            r_samples <= '0; r_pulses <= '0; r_spaces <= '0; r_bytes <= '0;
            r_done <= DONE_OPEN;
            r_has_item <= 1'b0; r_has_sample <= 1'b0; r_has_sum <= 1'b0;
            r_skip <= 1'b0;
        end else if (i_cmd.take) begin
            ph = r_phase; fi = r_fidx; dn = r_done;
            pc = r_pulses; sc = r_spaces; bc = r_bytes;
            pt = r_partial; pd = r_pdur;
            hi = 1'b0; hsa = 1'b0; hsu = 1'b0;
            have = 1'b0; c = '0; s = '0; v = '0;
            if (i_first_byte) begin
                ph = PH_INTERSPACE; fi = '0; dn = DONE_OPEN;
                pc = '0; sc = '0; bc = '0; pt = '0; pd = '0;
                r_total <= '0; r_samples <= '0;
            end
            r_skip <= (dn != DONE_OPEN);
            if (dn == DONE_OPEN) begin
                bc = bump(bc);
                v = {pt[7:0], i_data_byte};
                case (ph)
                    PH_INTERSPACE: begin
                        if (fi == 2'd0) begin
                            pt = 16'(i_data_byte); fi = 2'd1;
                        end else begin
                            s = 32'(v) * 32'd500;
                            hi = 1'b1; r_ikind <= KIND_INTERSPACE;
                            r_idur <= s[24:9]; r_icyc <= '0;
                            ph = PH_PULSE; fi = 2'd0;
                        end
                    end
                    PH_PULSE: begin
                        if (fi == 2'd0) begin
                            pt = 16'(i_data_byte); fi = 2'd1;
                        end else if (fi == 2'd1) begin
                            pd = v; fi = 2'd2;
                        end else if (fi == 2'd2) begin
                            if (i_data_byte[7]) begin
                                pt = {9'd0, i_data_byte[6:0]}; fi = 2'd3;
                            end else begin
                                c = 15'(i_data_byte); have = 1'b1;
                            end
                        end else begin
                            c = {pt[6:0], i_data_byte}; have = 1'b1;
                        end
                        if (have) begin
                            hsa = (c != '0) && (pd != '0);
                            r_icyc <= c;
                            pc = bump(pc);
                            hi = 1'b1; r_ikind <= KIND_PULSE;
                            r_idur <= pd;
                            ph = PH_SPACE; fi = 2'd0;
                        end
                    end
                    default: begin
                        if (fi == 2'd0) begin
                            if (i_data_byte == END_BYTE) begin
                                dn = DONE_COMPLETE;
                            end else begin
                                pt = 16'(i_data_byte); fi = 2'd1;
                            end
                        end else if (v > r_limit) begin
                            dn = DONE_PARTIAL;
                        end else begin
                            sc = bump(sc);
                            hi = 1'b1; r_ikind <= KIND_SPACE;
                            r_idur <= v; r_icyc <= '0;
                            ph = PH_PULSE; fi = 2'd0;
                        end
                    end
                endcase
                if (dn != DONE_OPEN) begin
                    hsu = 1'b1;
                end else if (i_last_byte) begin
                    dn = DONE_EARLY; hsu = 1'b1;
                end
            end
            r_phase <= ph; r_fidx <= fi; r_done <= dn;
            r_pulses <= pc; r_spaces <= sc; r_bytes <= bc;
            r_partial <= pt; r_pdur <= pd;
            r_has_item <= hi; r_has_sample <= hsa; r_has_sum <= hsu;
        end else begin
            if (i_cmd.acc) begin
                r_total <= r_total + r_term;
                r_samples <= bump(r_samples);
                r_has_sample <= 1'b0;
            end
            if (i_cmd.load_item) begin
                r_has_item <= 1'b0;
            end
        end
    end

    // divider: one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        logic [32:0] t;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start || i_cmd.sdiv_start) begin
            r_quo <= i_cmd.div_start ? 32'(FREQ_NUM) : r_total;
            r_dvs <= i_cmd.div_start ? 32'(r_pdur) : 32'(r_samples);
            r_rem <= '0;
            r_cnt <= 6'd32;
        end else if ((i_cmd.div_step || i_cmd.sdiv_step) && r_cnt != '0) begin
            t = {r_rem, r_quo[31]};
            if (t >= {1'b0, r_dvs}) begin
                r_rem <= 32'(t - {1'b0, r_dvs});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= t[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_term <= r_quo * (32'd10 * 32'(r_icyc) - 32'd5);
        end
        if (i_cmd.sdiv_step && r_cnt == 6'd0) begin
            r_avg <= (r_samples == '0) ? 32'd0 : r_quo;
        end
    end

    assign o_stat.has_item   = r_has_item;
    assign o_stat.has_sample = r_has_sample;
    assign o_stat.has_sum    = r_has_sum;
    assign o_stat.skip       = r_skip;
    assign o_stat.div_done   = (r_cnt == 6'd0);
    assign o_stat.out_busy   = r_ovalid && !i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        logic [COUNT_WIDTH-1:0] used;
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_ovalid <= 1'b1;
            o_kind <= r_ikind; o_duration <= r_idur; o_carrier_cycles <= r_icyc;
            o_carrier_freq <= '0; o_pulse_count <= '0; o_space_count <= '0;
            o_bytes_consumed <= '0; o_bytes_used <= '0; o_status <= ST_COMPLETE;
        end else if (i_cmd.load_sum) begin
            r_ovalid <= 1'b1;
            used = (r_bytes >= COUNT_WIDTH'(2)) ? r_bytes - COUNT_WIDTH'(2) : '0;
            o_kind <= KIND_SUMMARY; o_duration <= '0; o_carrier_cycles <= '0;
            o_carrier_freq <= r_avg;
            o_pulse_count <= cap16(r_pulses); o_space_count <= cap16(r_spaces);
            if (r_done == DONE_EARLY) begin
                o_bytes_consumed <= '0; o_bytes_used <= '0; o_status <= ST_EARLY;
            end else begin
                o_bytes_consumed <= cap16(r_bytes);
                o_bytes_used <= cap16((r_done == DONE_PARTIAL) ? used : r_bytes);
                o_status <= (r_samples == '0) ? ST_NOFREQ :
                            (r_done == DONE_PARTIAL) ? ST_PARTIAL : ST_COMPLETE;
            end
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_item || i_cmd.load_sum) |-> !(r_ovalid && !i_ready))
        else $error("output overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc |-> r_has_sample)
        else $error("acc without sample");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> r_pdur != '0)
        else $error("divide by zero duration");
endmodule

// ===== rtl/ir_raw_timing_parser.sv =====
// IR raw timing parser. One byte beat on the input channel yields at most two
// result beats: an interspace, pulse or space item and, when the frame ends or
// the buffer ends early, a summary. A byte beat is parsed and then waits on the
// output register; a pulse carrying a frequency sample adds the serial
// 250000/duration divide and the multiply-accumulate, and a summary adds the
// serial total/sample_count divide. A new byte beat is taken only once the last
// one is through. All divides share one bit-serial divider. The long-space limit
// is written on the cfg channel, reset value 16000.
module ir_raw_timing_parser
    import irp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_duration,
    output logic [14:0] o_carrier_cycles,
    output logic [31:0] o_carrier_freq,
    output logic [15:0] o_pulse_count,
    output logic [15:0] o_space_count,
    output logic [15:0] o_bytes_consumed,
    output logic [15:0] o_bytes_used,
    output logic [1:0]  o_status
);
    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    irp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    irp_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_data_byte(i_data_byte), .i_first_byte(i_first_byte),
        .i_last_byte(i_last_byte), .i_cfg_valid(i_cfg_valid),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .i_ready(i_ready),
        .o_kind(o_kind), .o_duration(o_duration),
        .o_carrier_cycles(o_carrier_cycles), .o_carrier_freq(o_carrier_freq),
        .o_pulse_count(o_pulse_count), .o_space_count(o_space_count),
        .o_bytes_consumed(o_bytes_consumed), .o_bytes_used(o_bytes_used),
        .o_status(o_status)
    );
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import irp_pkg::*;

    // one result beat, field for field as on the output port
    typedef struct {
        t_kind       kind;
        logic [15:0] duration;
        logic [14:0] cycles;
        logic [31:0] freq;
        logic [15:0] pulses;
        logic [15:0] spaces;
        logic [15:0] consumed;
        logic [15:0] used;
        t_status     status;
    } t_ir_item;

    // one byte beat on the input channel
    typedef struct {
        logic [7:0] data;
        bit         first;
        bit         last;
    } t_byte_beat;

    // Tracks the parse the block should be doing and holds the items it owes us.
    class frame_scoreboard;
        logic [15:0] limit;
        t_phase      phase;
        int          fidx;
        logic [15:0] partial;
        logic [15:0] pdur;
        logic [31:0] ftotal;
        logic [15:0] samples, pulses, spaces, nbytes;
        t_done       done;
        t_ir_item    due_items[$];
        int          errors;

        function void clear();
            phase   = PH_INTERSPACE;
            fidx    = 0;
            partial = 0;
            pdur    = 0;
            ftotal  = 0;
            samples = 0;
            pulses  = 0;
            spaces  = 0;
            nbytes  = 0;
            done    = DONE_OPEN;
        endfunction

        function new();
            limit  = LIMIT_RESET;
            errors = 0;
            clear();
        endfunction

        function logic [15:0] bump(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void push_item(t_kind k, logic [15:0] d, logic [14:0] c);
            t_ir_item r;
            r.kind     = k;
            r.duration = d;
            r.cycles   = c;
            r.freq     = 0;
            r.pulses   = 0;
            r.spaces   = 0;
            r.consumed = 0;
            r.used     = 0;
            r.status   = ST_COMPLETE;
            due_items.push_back(r);
        endfunction

        function void push_summary();
            t_ir_item r;
            r.kind     = KIND_SUMMARY;
            r.duration = 0;
            r.cycles   = 0;
            r.freq     = (samples != 0) ? ftotal / {16'd0, samples} : 32'd0;
            r.pulses   = pulses;
            r.spaces   = spaces;
            r.consumed = 0;
            r.used     = 0;
            if (done == DONE_EARLY) begin
                r.status = ST_EARLY;    // early end beats the no-sample status
            end else begin
                r.consumed = nbytes;
                r.used     = nbytes;
                if (done == DONE_PARTIAL)
                    r.used = (nbytes >= 2) ? nbytes - 16'd2 : 16'd0;
                if (samples == 0)
                    r.status = ST_NOFREQ;
                else
                    r.status = (done == DONE_PARTIAL) ? ST_PARTIAL : ST_COMPLETE;
            end
            due_items.push_back(r);
        endfunction

        function void note_byte(t_byte_beat bt);
            logic [15:0] v;
            logic [31:0] c, f;
            bit          have;
            have = 0;
            c    = 0;
            if (bt.first)
                clear();
            if (done != DONE_OPEN)
                return;     // tail of an ended frame: ignored
            nbytes = bump(nbytes);
            v = {partial[7:0], bt.data};
            case (phase)
                PH_INTERSPACE: begin
                    if (fidx == 0) begin
                        partial = 16'(bt.data);
                        fidx    = 1;
                    end else begin
                        push_item(KIND_INTERSPACE, 16'(({16'd0, v} * 32'd500) / 32'd512), 0);
                        phase = PH_PULSE;
                        fidx  = 0;
                    end
                end
                PH_PULSE: begin
                    if (fidx == 0) begin
                        partial = 16'(bt.data);
                        fidx    = 1;
                    end else if (fidx == 1) begin
                        pdur = v;
                        fidx = 2;
                    end else if (fidx == 2) begin
                        if (bt.data[7]) begin
                            partial = {9'd0, bt.data[6:0]};
                            fidx    = 3;
                        end else begin
                            c    = {24'd0, bt.data};
                            have = 1;
                        end
                    end else begin
                        c    = {17'd0, partial[6:0], bt.data};
                        have = 1;
                    end
                    if (have) begin
                        // zero count or zero duration: no frequency sample
                        if (c != 0 && pdur != 0) begin
                            f       = (32'd250000 / {16'd0, pdur}) * (32'd10 * c - 32'd5);
                            ftotal  = ftotal + f;
                            samples = bump(samples);
                        end
                        pulses = bump(pulses);
                        push_item(KIND_PULSE, pdur, c[14:0]);
                        phase = PH_SPACE;
                        fidx  = 0;
                    end
                end
                default: begin
                    if (fidx == 0) begin
                        if (bt.data == END_BYTE) begin
                            done = DONE_COMPLETE;
                        end else begin
                            partial = 16'(bt.data);
                            fidx    = 1;
                        end
                    end else if (v > limit) begin
                        done = DONE_PARTIAL;
                    end else begin
                        spaces = bump(spaces);
                        push_item(KIND_SPACE, v, 0);
                        phase = PH_PULSE;
                        fidx  = 0;
                    end
                end
            endcase
            if (done != DONE_OPEN) begin
                push_summary();
            end else if (bt.last) begin
                done = DONE_EARLY;
                push_summary();
            end
        endfunction

        function void check_result(t_ir_item got);
            t_ir_item exp_item;
            if (due_items.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %p", got);
                return;
            end
            exp_item = due_items.pop_front();
            if (got.kind !== exp_item.kind || got.duration !== exp_item.duration ||
                got.cycles !== exp_item.cycles || got.freq !== exp_item.freq ||
                got.pulses !== exp_item.pulses || got.spaces !== exp_item.spaces ||
                got.consumed !== exp_item.consumed || got.used !== exp_item.used ||
                got.status !== exp_item.status) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch\n  exp %p\n  got %p", exp_item, got);
            end
        endfunction
    endclass

    // dut ports
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_last_byte;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_duration;
    logic [14:0] o_carrier_cycles;
    logic [31:0] o_carrier_freq;
    logic [15:0] o_pulse_count;
    logic [15:0] o_space_count;
    logic [15:0] o_bytes_consumed;
    logic [15:0] o_bytes_used;
    logic [1:0]  o_status;

    ir_raw_timing_parser dut (.*);

    localparam int IDLE_LIMIT  = 5000;  // cycles without any beat before we give up
    localparam int DRAIN_WAIT  = 100;   // covers divide + mult-acc + summary divide

    frame_scoreboard sb;
    int  burst_left;
    int  idle_cycles;
    int  stall_age;
    logic [15:0] stall_pat;

    // starts low so the first rising edge comes after the initial setup
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Receiver: checks every result beat, stalls on a rotating pattern that is
    // redrawn whenever stall_age wraps; a quarter of the patterns never stall.
    always @(posedge i_clk) begin
        t_ir_item got;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind     = t_kind'(o_kind);
            got.duration = o_duration;
            got.cycles   = o_carrier_cycles;
            got.freq     = o_carrier_freq;
            got.pulses   = o_pulse_count;
            got.spaces   = o_space_count;
            got.consumed = o_bytes_consumed;
            got.used     = o_bytes_used;
            got.status   = t_status'(o_status);
            sb.check_result(got);
        end
        if (stall_age == 0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        else
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
        stall_age <= (stall_age + 1) % 64;
        i_ready   <= stall_pat[0];
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Sender: holds valid until the beat goes in, then maybe opens a gap.
    task automatic push_byte(t_byte_beat bt);
        i_valid      <= 1'b1;
        i_data_byte  <= bt.data;
        i_first_byte <= bt.first;
        i_last_byte  <= bt.last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_byte(bt);
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
    endtask

    task automatic send_beats(t_byte_beat q[$]);
        foreach (q[i])
            push_byte(q[i]);
    endtask

    // drain everything owed, then the write on the config channel
    task automatic write_limit(logic [15:0] v);
        if (i_valid)
            i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.limit = v;
    endtask

    function automatic void add_beat(ref t_byte_beat q[$], input logic [7:0] d,
                                     input bit f, input bit l);
        t_byte_beat bt;
        bt.data  = d;
        bt.first = f;
        bt.last  = l;
        q.push_back(bt);
    endfunction

    // Mostly well-formed frames with random content; a few end early, carry
    // junk after the end, or lack the start flag.
    function automatic void make_frame(ref t_byte_beat q[$], input logic [15:0] lim);
        logic [15:0] v;
        int          npulse, sel;
        q.delete();
        v = 16'($urandom);
        add_beat(q, v[15:8], $urandom_range(0, 9) != 0, 0);
        add_beat(q, v[7:0], 0, 0);
        npulse = $urandom_range(1, 6);
        for (int i = 0; i < npulse; i++) begin
            sel = $urandom_range(0, 9);
            v   = (sel == 0) ? 16'd0 : (sel == 1) ? 16'($urandom_range(1, 4)) : 16'($urandom);
            add_beat(q, v[15:8], 0, 0);
            add_beat(q, v[7:0], 0, 0);
            if ($urandom_range(0, 1)) begin
                add_beat(q, 8'($urandom_range(0, 127)), 0, 0);
            end else begin
                add_beat(q, 8'h80 | 8'($urandom_range(0, 127)), 0, 0);
                add_beat(q, 8'($urandom), 0, 0);
            end
            if (i < npulse - 1) begin
                v = (lim == 0) ? 16'd0 : 16'($urandom_range(0, lim));
                if (v[15:8] == END_BYTE)
                    v[15:8] = 8'hFE;
                add_beat(q, v[15:8], 0, 0);
                add_beat(q, v[7:0], 0, 0);
            end
        end
        sel = $urandom_range(0, 3);
        if (sel <= 1 || (sel == 2 && lim == 16'hFFFF)) begin
            add_beat(q, END_BYTE, 0, $urandom_range(0, 4) == 0);
        end else if (sel == 2) begin
            v = 16'($urandom_range(32'(lim) + 1, 65535));
            add_beat(q, v[15:8], 0, 0);
            add_beat(q, v[7:0], 0, $urandom_range(0, 4) == 0);
        end else begin
            q[$urandom_range(0, q.size() - 1)].last = 1;   // buffer cut short
        end
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3))
                add_beat(q, 8'($urandom), 0, $urandom_range(0, 1));
    endfunction

    initial begin
        t_byte_beat  q[$];
        logic [15:0] limits[4];
        int          sent;
        sb          = new();
        burst_left  = 5;
        idle_cycles = 0;
        stall_age   = 0;
        stall_pat   = 16'hFFFF;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= 8'd0;
        i_first_byte <= 1'b0;
        i_last_byte  <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= 16'd0;
        i_ready      <= 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed. First frame from reset without a start flag:
        // max interspace, zero-duration pulse, space 0, max duration with max
        // two-byte count, space at the limit, count of 1 on duration 1,
        // space 0, two-byte zero count, clean end.
        add_beat(q, 8'hFF, 0, 0); add_beat(q, 8'hFF, 0, 0);
        add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h05, 0, 0);
        add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h00, 0, 0);
        add_beat(q, 8'hFF, 0, 0); add_beat(q, 8'hFF, 0, 0);
        add_beat(q, 8'hFF, 0, 0); add_beat(q, 8'hFF, 0, 0);
        add_beat(q, 8'h3E, 0, 0); add_beat(q, 8'h80, 0, 0);   // space exactly at limit
        add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h01, 0, 0); add_beat(q, 8'h01, 0, 0);
        add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h00, 0, 0);
        add_beat(q, 8'h00, 0, 0); add_beat(q, 8'h02, 0, 0);
        add_beat(q, 8'h80, 0, 0); add_beat(q, 8'h00, 0, 0);
        add_beat(q, END_BYTE, 0, 0);
        add_beat(q, 8'h55, 0, 1);                              // ignored after the end
        send_beats(q);
        // no-sample frame ending on a long space, then a buffer cut short
        q.delete();
        add_beat(q, 8'h00, 1, 0); add_beat(q, 8'h00, 0, 0);
        add_beat(q, 8'h12, 0, 0); add_beat(q, 8'h34, 0, 0); add_beat(q, 8'h00, 0, 0);
        add_beat(q, 8'h3E, 0, 0); add_beat(q, 8'h81, 0, 0);
        add_beat(q, 8'hAA, 1, 0); add_beat(q, 8'h55, 0, 0);
        add_beat(q, 8'h01, 0, 0); add_beat(q, 8'hF4, 0, 1);
        send_beats(q);

        limits[0] = 16'd0;
        limits[1] = 16'hFFFF;
        limits[2] = 16'($urandom);
        limits[3] = LIMIT_RESET;
        foreach (limits[p]) begin
            write_limit(limits[p]);
            sent = 0;
            while (sent < 310) begin
                make_frame(q, limits[p]);
                sent += q.size();
                send_beats(q);
            end
        end

        if (i_valid)
            i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_items.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/irp_pkg.sv
rtl/irp_ctrl.sv
rtl/irp_datapath.sv
rtl/ir_raw_timing_parser.sv
dv/tb_top.sv
